// ----- hw/rtl/double_ended_priority_queue_core_assert.svh -----
// Assertion macros used by the queue top level.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DEPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("depq assertion failed");
`define DEPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("depq assertion failed");
`else
`define DEPQ_ASSERT_IMP(lbl, ante, cons)
`define DEPQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/depq_pkg.sv -----
// Types and constants of the double-ended priority queue.
package depq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP_MIN = 2'd1,
    MODE_POP_MAX = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-cycle command to every cell of a chain.
  typedef struct packed {
    logic push;
    logic pop_front;
    logic pop_back;
  } cell_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    key_t key;
    logic valid;
    logic ahead;
  } link_t;

endpackage

// ----- hw/rtl/depq_if.sv -----
// Channel interfaces: operation input and result output.
interface depq_in_if;
  import depq_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  key_t       key_in;

  modport source (output valid, output mode, output key_in, input ready);
  modport sink   (input valid, input mode, input key_in, output ready);
endinterface

interface depq_out_if;
  import depq_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  key_t       removed_key;
  key_t       min_key;
  key_t       max_key;
  cnt_t       entry_count;

  modport source (output valid, output status, output removed_key, output min_key,
                  output max_key, output entry_count, input ready);
  modport sink   (input valid, input status, input removed_key, input min_key,
                  input max_key, input entry_count, output ready);
endinterface

// ----- hw/rtl/depq_cell.sv -----
// One cell of a sorted chain: holds a key and its valid bit.
module depq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  depq_pkg::cell_cmd_t cmd,
  input  logic              desc,
  input  depq_pkg::key_t    key_in,
  input  depq_pkg::link_t   left,
  input  depq_pkg::link_t   right,
  output depq_pkg::link_t   link
);
  import depq_pkg::*;

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;
  logic ahead;

  // New key sorts ahead of this cell (an empty cell counts as infinitely far).
  assign ahead = !valid_r || (desc ? (key_in > key_r) : (key_in < key_r));

  assign link.key   = key_r;
  assign link.valid = valid_r;
  assign link.ahead = ahead;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (cmd.push) begin
      valid_nxt = valid_r | left.valid;
      if (left.ahead) begin
        key_nxt = left.key;
      end else if (ahead) begin
        key_nxt = key_in;
      end
    end else if (cmd.pop_front) begin
      key_nxt   = right.key;
      valid_nxt = right.valid;
    end else if (cmd.pop_back) begin
      valid_nxt = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end
endmodule

// ----- hw/rtl/depq_chain.sv -----
// Row of cells kept sorted, ascending or descending, head at cell zero.
module depq_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  depq_pkg::cell_cmd_t cmd,
  input  logic                desc,
  input  depq_pkg::key_t      key_in,
  output depq_pkg::link_t     head0,
  output depq_pkg::link_t     head1
);
  import depq_pkg::*;

  link_t links [CAPACITY];
  link_t head_edge;
  link_t tail_edge;

  assign head_edge = '{key: '0, valid: 1'b1, ahead: 1'b0};
  assign tail_edge = '{key: '0, valid: 1'b0, ahead: 1'b1};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = head_edge;
    end else begin : g_mid_l
      assign left_w = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = tail_edge;
    end else begin : g_mid_r
      assign right_w = links[i+1];
    end
    depq_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .desc   (desc),
      .key_in (key_in),
      .left   (left_w),
      .right  (right_w),
      .link   (links[i])
    );
  end

  assign head0 = links[0];
  assign head1 = links[1];
endmodule

// ----- hw/rtl/double_ended_priority_queue_core.sv -----
// Double-ended priority queue of signed 32-bit keys, top level.
//
// in_chan carries one operation per transfer: mode 0 pushes key_in, mode 1
// removes the minimum, mode 2 removes the maximum; mode 3 changes nothing.
// out_chan returns one result per operation: status (ok, full, empty), the
// removed key, the minimum and maximum held afterwards and the key count.
// The keys live twice, in an ascending and a descending row of cells, so
// the minimum and maximum always sit in the first cell of a row.
// The result is valid in the cycle after the input transfer; one operation
// is taken per cycle while the receiver keeps up, since every cell compares
// the key and moves to its neighbor's value in the same cycle.
// The result register parts the two sides: a new operation is taken while
// the result waits as long as out_chan.ready is high in that cycle; when
// the receiver stalls, in_chan.ready drops and the queue holds.
// Synchronous reset empties the queue and drops any pending result.
// Push when full and pop when empty change nothing and report status.
module double_ended_priority_queue_core (
  input logic        clk,
  input logic        rst_n,
  depq_in_if.sink    in_chan,
  depq_out_if.source out_chan
);
  import depq_pkg::*;
  `include "double_ended_priority_queue_core_assert.svh"

  cnt_t      cnt_r, cnt_nxt;
  logic      out_valid_r;
  status_e   status_r, status_nxt;
  key_t      removed_r, removed_nxt;
  key_t      min_r, min_nxt;
  key_t      max_r, max_nxt;
  cell_cmd_t cmd_asc, cmd_desc;
  link_t     a_h0, a_h1, d_h0, d_h1;
  mode_e     mode_w;
  logic      accept;
  logic      full;
  logic      empty;
  logic      multi;

  assign mode_w = mode_e'(in_chan.mode);
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept = in_chan.valid && in_chan.ready;
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign empty  = (cnt_r == '0);
  assign multi  = (cnt_r > CNT_W'(1));

  always_comb begin
    cmd_asc     = '0;
    cmd_desc    = '0;
    cnt_nxt     = cnt_r;
    status_nxt  = ST_OK;
    removed_nxt = '0;
    min_nxt     = empty ? '0 : a_h0.key;
    max_nxt     = empty ? '0 : d_h0.key;
    unique case (mode_w)
      MODE_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd_asc.push  = accept;
          cmd_desc.push = accept;
          cnt_nxt       = cnt_r + 1'b1;
          min_nxt = (empty || in_chan.key_in < a_h0.key) ? in_chan.key_in : a_h0.key;
          max_nxt = (empty || in_chan.key_in > d_h0.key) ? in_chan.key_in : d_h0.key;
        end
      end
      MODE_POP_MIN: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd_asc.pop_front = accept;
          cmd_desc.pop_back = accept;
          cnt_nxt     = cnt_r - 1'b1;
          removed_nxt = a_h0.key;
          min_nxt     = multi ? a_h1.key : '0;
          max_nxt     = multi ? d_h0.key : '0;
        end
      end
      MODE_POP_MAX: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd_desc.pop_front = accept;
          cmd_asc.pop_back   = accept;
          cnt_nxt     = cnt_r - 1'b1;
          removed_nxt = d_h0.key;
          min_nxt     = multi ? a_h0.key : '0;
          max_nxt     = multi ? d_h1.key : '0;
        end
      end
      default: begin
        // unused code: report current contents, change nothing
      end
    endcase
  end

  depq_chain u_asc (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd_asc),
    .desc   (1'b0),
    .key_in (in_chan.key_in),
    .head0  (a_h0),
    .head1  (a_h1)
  );

  depq_chain u_desc (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd_desc),
    .desc   (1'b1),
    .key_in (in_chan.key_in),
    .head0  (d_h0),
    .head1  (d_h1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on every input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.removed_key = removed_r;
  assign out_chan.min_key     = min_r;
  assign out_chan.max_key     = max_r;
  assign out_chan.entry_count = cnt_r;

  `DEPQ_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `DEPQ_ASSERT_IMP(a_head_valid, 1'b1, (cnt_r != '0) == a_h0.valid && a_h0.valid == d_h0.valid)
  `DEPQ_ASSERT_IMP(a_head_order, a_h0.valid, a_h0.key <= d_h0.key)
  `DEPQ_ASSERT_NXT(a_push_count, accept && mode_w == MODE_PUSH && !full,
                   cnt_r == $past(cnt_r) + 1'b1)
  `DEPQ_ASSERT_IMP(a_full_cap, out_valid_r && status_r == ST_FULL,
                   cnt_r == CNT_W'(CAPACITY))
endmodule

// ----- tb/double_ended_priority_queue_core_test.sv -----
// Self-checking testbench of the double-ended priority queue core.
module double_ended_priority_queue_core_test;
  import depq_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam key_t KEY_MIN = key_t'(32'h8000_0000);
  localparam key_t KEY_MAX = key_t'(32'h7fff_ffff);
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_OPS = 1300;

  typedef struct packed {
    logic [1:0] mode;
    key_t       key;
  } queue_op_t;

  typedef struct {
    logic [1:0] status;
    key_t       removed;
    key_t       min_k;
    key_t       max_k;
    cnt_t       count;
  } queue_result_t;

  logic clk;
  logic rst_n;

  depq_in_if  in_if ();
  depq_out_if out_if ();

  double_ended_priority_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Interval heap kept alongside the block: low ends at even slots, high at odd.
  key_t          heap_keys [CAPACITY];
  int unsigned   held_keys = 0;

  queue_op_t     pending_ops [$];
  queue_result_t results_due [$];
  queue_op_t     offered;

  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  no_idle = 1'b0;
  int  mismatches = 0;
  int  ops_queued = 0;
  int  ops_done = 0;
  int  full_seen = 0;
  int  empty_seen = 0;
  int  phase;
  int  push_pct;
  int  len;
  int  r;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned hi_slot(int unsigned node, int unsigned cnt);
    return (2 * node + 1 < cnt) ? 2 * node + 1 : 2 * node;
  endfunction

  function automatic void sift_up_min(int unsigned node, key_t v);
    int unsigned par;
    bit done;
    done = 1'b0;
    while (node > 0 && !done) begin
      par = (node - 1) / 2;
      if (v < heap_keys[2 * par]) begin
        heap_keys[2 * node] = heap_keys[2 * par];
        node = par;
      end else begin
        done = 1'b1;
      end
    end
    heap_keys[2 * node] = v;
  endfunction

  function automatic void sift_up_max(int unsigned node, int unsigned slot, key_t v);
    int unsigned par;
    bit done;
    done = 1'b0;
    while (node > 0 && !done) begin
      par = (node - 1) / 2;
      if (v > heap_keys[2 * par + 1]) begin
        heap_keys[slot] = heap_keys[2 * par + 1];
        node = par;
        slot = 2 * par + 1;
      end else begin
        done = 1'b1;
      end
    end
    heap_keys[slot] = v;
  endfunction

  // Refill the root's low end with v; cnt keys remain.
  function automatic void sift_down_min(key_t v, int unsigned cnt);
    int unsigned node, hs, c1, c2, best;
    key_t t;
    bit done;
    node = 0;
    done = 1'b0;
    while (!done) begin
      hs = 2 * node + 1;
      c1 = 2 * node + 1;
      c2 = 2 * node + 2;
      if (hs < cnt && v > heap_keys[hs]) begin
        t = heap_keys[hs];
        heap_keys[hs] = v;
        v = t;
      end
      if (2 * c1 >= cnt) begin
        done = 1'b1;
      end else begin
        best = c1;
        if (2 * c2 < cnt && heap_keys[2 * c2] < heap_keys[2 * c1]) best = c2;
        if (heap_keys[2 * best] < v) begin
          heap_keys[2 * node] = heap_keys[2 * best];
          node = best;
        end else begin
          done = 1'b1;
        end
      end
    end
    heap_keys[2 * node] = v;
  endfunction

  // Refill the root's high end with v; cnt keys remain.
  function automatic void sift_down_max(key_t v, int unsigned cnt);
    int unsigned node, c1, c2, best;
    key_t t;
    bit done;
    node = 0;
    done = 1'b0;
    while (!done) begin
      c1 = 2 * node + 1;
      c2 = 2 * node + 2;
      if (2 * node + 1 < cnt && v < heap_keys[2 * node]) begin
        t = heap_keys[2 * node];
        heap_keys[2 * node] = v;
        v = t;
      end
      if (2 * c1 >= cnt) begin
        done = 1'b1;
      end else begin
        best = c1;
        if (2 * c2 < cnt && heap_keys[hi_slot(c2, cnt)] > heap_keys[hi_slot(c1, cnt)])
          best = c2;
        if (heap_keys[hi_slot(best, cnt)] > v) begin
          heap_keys[hi_slot(node, cnt)] = heap_keys[hi_slot(best, cnt)];
          node = best;
        end else begin
          done = 1'b1;
        end
      end
    end
    heap_keys[hi_slot(node, cnt)] = v;
  endfunction

  function automatic logic [1:0] heap_push(key_t x);
    int unsigned c, node, par;
    key_t old;
    c = held_keys;
    if (c >= CAPACITY) return ST_FULL;
    if (c == 0) begin
      heap_keys[0] = x;
    end else if (c % 2 == 1) begin
      node = (c - 1) / 2;
      old = heap_keys[c - 1];
      if (x < old) begin
        heap_keys[c] = old;
        sift_up_min(node, x);
      end else begin
        sift_up_max(node, c, x);
      end
    end else begin
      node = c / 2;
      par = (node - 1) / 2;
      if (x < heap_keys[2 * par]) sift_up_min(node, x);
      else if (x > heap_keys[2 * par + 1]) sift_up_max(node, c, x);
      else heap_keys[c] = x;
    end
    held_keys = c + 1;
    return ST_OK;
  endfunction

  function automatic queue_result_t apply_op(queue_op_t op);
    queue_result_t res;
    int unsigned c;
    c = held_keys;
    res.status = ST_OK;
    res.removed = '0;
    case (op.mode)
      MODE_PUSH: res.status = heap_push(op.key);
      MODE_POP_MIN, MODE_POP_MAX: begin
        if (c == 0) begin
          res.status = ST_EMPTY;
        end else if (op.mode == MODE_POP_MIN) begin
          res.removed = heap_keys[0];
          held_keys = c - 1;
          if (c > 1) sift_down_min(heap_keys[c - 1], c - 1);
        end else begin
          res.removed = (c == 1) ? heap_keys[0] : heap_keys[1];
          if (c > 2) sift_down_max(heap_keys[c - 1], c - 1);
          held_keys = c - 1;
        end
      end
      default: ;
    endcase
    c = held_keys;
    res.min_k = (c == 0) ? key_t'(0) : heap_keys[0];
    res.max_k = (c == 0) ? key_t'(0) : heap_keys[(c == 1) ? 0 : 1];
    res.count = cnt_t'(c);
    if (res.status == ST_FULL) full_seen++;
    if (res.status == ST_EMPTY) empty_seen++;
    ops_done++;
    return res;
  endfunction

  function automatic key_t draw_key();
    case ($urandom_range(0, 7))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2, 3, 4: return key_t'(int'($urandom_range(0, 16)) - 8);
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic queue_op(input logic [1:0] m, input key_t k);
    queue_op_t op;
    op.mode = m;
    op.key = k;
    pending_ops.push_back(op);
    if (m != MODE_NOP) ops_queued++;
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_if.valid || results_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [32:0] want,
                             input logic signed [32:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: offer queued operations, predict each one at its transfer.
  always @(posedge clk) begin
    logic offering;
    queue_op_t op;
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      in_if.mode   <= MODE_PUSH;
      in_if.key_in <= '0;
      in_gap = 0;
    end else begin
      offering = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        results_due.push_back(apply_op(offered));
        offering = 1'b0;
        in_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (!offering) begin
        if (in_gap != 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops.pop_front();
          offered = op;
          in_if.mode   <= op.mode;
          in_if.key_in <= op.key;
          in_if.valid  <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted on its own.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no operation outstanding", $time);
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, out_if.status);
          check_field("removed_key", want.removed, out_if.removed_key);
          check_field("min_key", want.min_k, out_if.min_key);
          check_field("max_key", want.max_k, out_if.max_key);
          check_field("entry_count", want.count, out_if.entry_count);
        end
        out_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_PUSH;
    in_if.key_in = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pops, ignored mode, extreme keys, ties, last-key pops.
    queue_op(MODE_POP_MIN, KEY_MAX);
    queue_op(MODE_POP_MAX, KEY_MIN);
    queue_op(MODE_NOP, key_t'(32'hffff_ffff));
    queue_op(MODE_PUSH, KEY_MAX);
    queue_op(MODE_PUSH, KEY_MIN);
    queue_op(MODE_POP_MAX, '0);
    queue_op(MODE_POP_MAX, '0);
    queue_op(MODE_PUSH, KEY_MIN);
    queue_op(MODE_POP_MIN, '0);
    queue_op(MODE_PUSH, key_t'(0));
    queue_op(MODE_PUSH, key_t'(0));
    queue_op(MODE_PUSH, key_t'(-1));
    queue_op(MODE_PUSH, key_t'(5));
    queue_op(MODE_PUSH, key_t'(5));
    queue_op(MODE_PUSH, key_t'(0));
    queue_op(MODE_NOP, '0);
    queue_op(MODE_POP_MIN, '0);
    queue_op(MODE_POP_MAX, '0);
    queue_op(MODE_POP_MIN, '0);
    queue_op(MODE_POP_MAX, '0);
    queue_op(MODE_POP_MIN, '0);
    queue_op(MODE_POP_MAX, '0);
    queue_op(MODE_POP_MIN, '0);
    wait_idle();

    // Random: alternate fill, mixed and drain phases to reach full and empty.
    ops_queued = 0;
    phase = 0;
    while (ops_queued < RANDOM_OPS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case (phase % 3)
        0: push_pct = 90;
        1: push_pct = 50;
        default: push_pct = 10;
      endcase
      if (phase == 3) hold_req = 1'b1;
      len = $urandom_range(60, 140);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) queue_op(MODE_PUSH, draw_key());
        else if (r < 97) queue_op($urandom_range(0, 1) ? MODE_POP_MIN : MODE_POP_MAX, draw_key());
        else queue_op(MODE_NOP, draw_key());
      end
      // Pause the sender until every result of the phase is back.
      wait_idle();
      phase++;
    end

    repeat (4) @(negedge clk);
    if (results_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, results_due.size());
    end
    $display("Ran %0d operations in %0d phases with random stalls and a long hold-off;",
             ops_done, phase);
    $display("full refusals: %0d, empty refusals: %0d, mismatches: %0d",
             full_seen, empty_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("TB_ERROR");
    $finish;
  end

endmodule
